// ===== rtl/lksbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lksbd_pkg
// Types and constants shared by the keyed substitution byte decryptor.
// ----------------------------------------------------------------------------
package lksbd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SEED_W = 32;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SEED_W-1:0] seed_t;

  localparam seed_t LCG_MUL    = 32'd214013;
  localparam seed_t LCG_INC    = 32'd2531011;
  localparam seed_t RESET_SEED = 32'h0342_9195;
  localparam byte_t LAST_IDX   = 8'hFF;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_DRAW,
    ST_READ,
    ST_WR_I,
    ST_WR_J,
    ST_INV,
    ST_RUN
  } build_state_t;

endpackage
`default_nettype wire

// ===== rtl/lksbd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lksbd_in_if
// Cipher byte channel: valid/ready handshake with byte and start mark.
// ----------------------------------------------------------------------------
interface lksbd_in_if;
  import lksbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t cipher_byte;
  logic  start_of_file;

  modport source (output valid, output cipher_byte, output start_of_file, input ready);
  modport sink   (input valid, input cipher_byte, input start_of_file, output ready);
endinterface
`default_nettype wire

// ===== rtl/lksbd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lksbd_out_if
// Plain byte channel: valid/ready handshake with the decrypted byte.
// ----------------------------------------------------------------------------
interface lksbd_out_if;
  import lksbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/lksbd_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lksbd_cfg_if
// Seed write channel: valid/ready handshake with the generator seed.
// ----------------------------------------------------------------------------
interface lksbd_cfg_if;
  import lksbd_pkg::*;

  logic  valid;
  logic  ready;
  seed_t key_seed;

  modport source (output valid, output key_seed, input ready);
  modport sink   (input valid, input key_seed, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcg_keyed_substitution_byte_decrypt_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_keyed_substitution_byte_decrypt_core
// Byte-stream decryptor with a substitution table built from a seeded
// linear congruential generator.
// ----------------------------------------------------------------------------
// Once the table is built the core takes one cipher byte per clock and
// returns its plain byte in the next cycle from the output register; the rate
// is set by the single read of the inverse table memory per item, and
// in_ch.ready also follows out_ch.ready when the output register is full.
// After reset and after every seed write the core rebuilds its tables and
// holds in_ch.ready and cfg_ch.ready low until it is done: it fills the
// permutation memory with the identity, makes the 256 swaps (draw, read both
// entries, write each back through the single write port), and then writes
// the inverse table. The previous cipher byte is kept across seed writes.
// ----------------------------------------------------------------------------
module lcg_keyed_substitution_byte_decrypt_core (
  input  wire          clk,
  input  wire          rst_n,
  lksbd_in_if.sink     in_ch,
  lksbd_out_if.source  out_ch,
  lksbd_cfg_if.sink    cfg_ch
);
  import lksbd_pkg::*;

  build_state_t state_r, state_nxt;
  byte_t        cnt_r;
  seed_t        gen_r;
  byte_t        prev_r;
  logic         inv_pend_r;
  byte_t        inv_idx_r;
  logic         out_valid_r;
  byte_t        plain_r;

  byte_t        shf_mem [0:255];
  byte_t        inv_mem [0:255];
  byte_t        shf_rd0_r, shf_rd1_r;

  logic         shf_we;
  byte_t        shf_waddr;
  byte_t        shf_wdata;
  logic         shf_re;
  logic         run_idle;
  logic         in_acc;
  logic         cfg_acc;
  byte_t        draw_idx;
  byte_t        rd_idx;

  assign draw_idx = gen_r[23:16];
  assign run_idle = (state_r == ST_RUN) && !inv_pend_r;
  assign in_ch.ready  = run_idle && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = run_idle;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign rd_idx  = in_ch.cipher_byte - (in_ch.start_of_file ? '0 : prev_r);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.plain_byte = plain_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: if (cnt_r == LAST_IDX) state_nxt = ST_DRAW;
      ST_DRAW: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_WR_I;
      ST_WR_I: state_nxt = ST_WR_J;
      ST_WR_J: state_nxt = (cnt_r == LAST_IDX) ? ST_INV : ST_DRAW;
      ST_INV:  if (cnt_r == LAST_IDX) state_nxt = ST_RUN;
      ST_RUN:  if (cfg_acc) state_nxt = ST_INIT;
      default: state_nxt = ST_INIT;
    endcase
  end

  // permutation memory controls
  always_comb begin
    shf_we    = 1'b0;
    shf_waddr = cnt_r;
    shf_wdata = cnt_r;
    shf_re    = 1'b0;
    case (state_r)
      ST_INIT: shf_we = 1'b1;
      ST_READ: shf_re = 1'b1;
      ST_WR_I: begin
        shf_we    = 1'b1;
        shf_wdata = shf_rd1_r;
      end
      ST_WR_J: begin
        shf_we    = 1'b1;
        shf_waddr = draw_idx;
        shf_wdata = shf_rd0_r;
      end
      ST_INV:  shf_re = 1'b1;
      default: shf_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      gen_r       <= RESET_SEED;
      prev_r      <= '0;
      inv_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      inv_pend_r <= (state_r == ST_INV);
      if (state_r == ST_INIT || state_r == ST_WR_J || state_r == ST_INV) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_DRAW) begin
        gen_r <= gen_r * LCG_MUL + LCG_INC;
      end else if (cfg_acc) begin
        gen_r <= cfg_ch.key_seed;
      end
      if (in_acc) begin
        prev_r      <= in_ch.cipher_byte;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // permutation memory, two read ports
  always_ff @(posedge clk) begin
    if (shf_we) begin
      shf_mem[shf_waddr] <= shf_wdata;
    end
    if (shf_re) begin
      shf_rd0_r <= shf_mem[cnt_r];
      shf_rd1_r <= shf_mem[draw_idx];
    end
  end

  // inverse table memory
  always_ff @(posedge clk) begin
    inv_idx_r <= cnt_r;
    if (inv_pend_r) begin
      inv_mem[shf_rd0_r] <= inv_idx_r;
    end
    if (in_acc) begin
      plain_r <= inv_mem[rd_idx];
    end
  end

endmodule
`default_nettype wire

// ===== tb/lcg_keyed_substitution_byte_decrypt_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_keyed_substitution_byte_decrypt_core_tb
// Self-checking bench for the keyed substitution byte decryptor.
// A queue of cipher items feeds a clocked driver. A clocked monitor keeps its
// own copy of the generator, the shuffled table, its inverse and the previous
// cipher byte. Every accepted item gives an expected plain byte, and each
// returned item is checked in order against it. The key seed is rewritten
// between phases, with the extremes among the values used. Each phase uses a
// different pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lcg_keyed_substitution_byte_decrypt_core_tb;
  import lksbd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned NUM_PHASES     = 4;
  localparam int unsigned PHASE_ITEMS    = 175;

  typedef struct {
    byte_t cipher;
    logic  sof;
  } cipher_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lksbd_in_if  in_ch ();
  lksbd_out_if out_ch ();
  lksbd_cfg_if cfg_ch ();

  lcg_keyed_substitution_byte_decrypt_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cipher_item_t cipher_q[$];
  byte_t        plain_expected_q[$];

  byte_t       inv_tbl [256];
  byte_t       prev_cipher;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned seed_writes;
  int unsigned idle_cycles;
  logic        in_hs;
  logic        out_hs;
  logic        cfg_hs;

  function automatic void build_substitution(input seed_t seed);
    seed_t       lcg;
    byte_t       fwd [256];
    byte_t       t;
    byte_t       j;
    lcg = seed;
    for (int i = 0; i < 256; i++) fwd[i] = byte_t'(i);
    for (int i = 0; i < 256; i++) begin
      lcg = lcg * LCG_MUL + LCG_INC;
      // draw keeps bits 23..16 of the new state, (state >> 16) mod 256
      j = lcg[23:16];
      t = fwd[i];
      fwd[i] = fwd[j];
      fwd[j] = t;
    end
    for (int i = 0; i < 256; i++) inv_tbl[fwd[i]] = byte_t'(i);
  endfunction

  // monitor and predictor
  always @(posedge clk) begin
    in_hs  = rst_n && in_ch.valid && in_ch.ready;
    out_hs = rst_n && out_ch.valid && out_ch.ready;
    cfg_hs = rst_n && cfg_ch.valid && cfg_ch.ready;
    if (cfg_hs) begin
      build_substitution(cfg_ch.key_seed);
      seed_writes++;
    end
    if (out_hs) begin
      if (plain_expected_q.size() == 0) begin
        $error("plain_byte: unexpected item %02h with nothing expected", out_ch.plain_byte);
        error_count++;
      end else begin
        if (out_ch.plain_byte !== plain_expected_q[0]) begin
          $error("plain_byte mismatch: expected %02h, actual %02h",
                 plain_expected_q[0], out_ch.plain_byte);
          error_count++;
        end
        void'(plain_expected_q.pop_front());
        results_checked++;
      end
    end
    if (in_hs) begin
      plain_expected_q.push_back(
        inv_tbl[byte_t'(in_ch.cipher_byte - (in_ch.start_of_file ? 8'h00 : prev_cipher))]);
      prev_cipher = in_ch.cipher_byte;
      items_sent++;
    end
    if (in_hs || out_hs || cfg_hs) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // cipher item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_hs) begin
      if (cipher_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_ch.valid         <= 1'b1;
        in_ch.cipher_byte   <= cipher_q[0].cipher;
        in_ch.start_of_file <= cipher_q[0].sof;
        void'(cipher_q.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // plain item receiver
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic wait_drained();
    while (cipher_q.size() != 0 || in_ch.valid || plain_expected_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_seed(input seed_t seed);
    @(negedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.key_seed <= seed;
    do @(negedge clk); while (!cfg_hs);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    cipher_item_t item;
    seed_t        phase_seed [NUM_PHASES];
    int unsigned  gap_pct [NUM_PHASES];
    int unsigned  stall_pct [NUM_PHASES];
    int unsigned  run_len;

    in_ch.valid         = 1'b0;
    in_ch.cipher_byte   = '0;
    in_ch.start_of_file = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.key_seed     = '0;
    error_count         = 0;
    items_sent          = 0;
    results_checked     = 0;
    seed_writes         = 0;
    idle_cycles         = 0;
    in_hs               = 1'b0;
    out_hs              = 1'b0;
    cfg_hs              = 1'b0;
    send_gap_pct        = 0;
    recv_stall_pct      = 0;
    prev_cipher         = '0;
    build_substitution(RESET_SEED);

    phase_seed = '{32'h0000_0000, 32'hFFFF_FFFF, seed_t'($urandom), seed_t'($urandom)};
    gap_pct    = '{0, 50, 0, 31};
    stall_pct  = '{0, 0, 50, 31};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items on the reset table: extremes, wrap-around, start marks
    @(posedge clk);
    cipher_q.push_back('{8'h00, 1'b1});
    cipher_q.push_back('{8'hFF, 1'b0});
    cipher_q.push_back('{8'h00, 1'b0});
    cipher_q.push_back('{8'h00, 1'b0});
    cipher_q.push_back('{8'hFF, 1'b0});
    cipher_q.push_back('{8'hFE, 1'b0});
    cipher_q.push_back('{8'h80, 1'b0});
    cipher_q.push_back('{8'h7F, 1'b0});
    cipher_q.push_back('{8'h01, 1'b1});
    cipher_q.push_back('{8'h01, 1'b0});
    cipher_q.push_back('{8'hAA, 1'b0});
    cipher_q.push_back('{8'h55, 1'b0});
    cipher_q.push_back('{8'h55, 1'b1});
    cipher_q.push_back('{8'hFF, 1'b1});
    cipher_q.push_back('{8'h00, 1'b1});
    cipher_q.push_back('{8'hC3, 1'b0});
    cipher_q.push_back('{8'h3C, 1'b0});
    cipher_q.push_back('{8'hFF, 1'b0});
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_seed(phase_seed[p]);
      send_gap_pct   = gap_pct[p];
      recv_stall_pct = stall_pct[p];
      @(posedge clk);
      run_len = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.cipher = byte_t'($urandom);
        // mostly well-formed files, some missing or stray start marks
        if (run_len == 0) begin
          item.sof = ($urandom_range(99) < 85);
          run_len  = $urandom_range(40, 1);
        end else begin
          item.sof = ($urandom_range(99) < 4);
          run_len--;
        end
        cipher_q.push_back(item);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d cipher items, %0d plain items checked, %0d seed writes",
             items_sent, results_checked, seed_writes);
    $display("seeds: reset value, zero, all ones and two random; four idle patterns");
    if (error_count == 0 && plain_expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== lcg_keyed_substitution_byte_decrypt_core.f =====
rtl/lksbd_pkg.sv
rtl/lksbd_in_if.sv
rtl/lksbd_out_if.sv
rtl/lksbd_cfg_if.sv
rtl/lcg_keyed_substitution_byte_decrypt_core.sv
tb/lcg_keyed_substitution_byte_decrypt_core_tb.sv
